### design/stu_pkg.sv
// Package for the stereo to surround upmix block: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps
package stu_pkg;
	localparam int VOLUME_SHIFT = 12;
	localparam int CFG_IDX_W = 3;
	localparam logic signed [33:0] Q_ONE = 34'sd268435456;
	localparam logic signed [33:0] K_ENV = 34'sd26843546;
	localparam logic signed [33:0] K_CLAMP = 34'sd241591910;
	localparam logic signed [33:0] K_MAJOR = 34'sd464393339;
	localparam logic signed [33:0] K_MINOR = 34'sd327491256;
	localparam logic signed [33:0] K_REAR = 34'sd182536110;
	localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
	localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_LEFT, REG_GAIN_RIGHT, REG_GAIN_CENTER, REG_GAIN_LFE,
		REG_GAIN_REAR_LEFT, REG_GAIN_REAR_RIGHT, REG_CENTER_BLEND
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_ENV_L, OP_ENV_R, OP_FRONT, OP_L, OP_R, OP_DIV_L, OP_DIV_R,
		OP_SL_A, OP_SL_B, OP_SR_A, OP_SR_B, OP_SL_C, OP_SL_D, OP_SR_C, OP_SR_D,
		OP_CX, OP_FL, OP_FR, OP_C, OP_LFE, OP_RL, OP_RR
	} op_t;

	typedef enum logic [2:0] {ST_IDLE, ST_STEP, ST_DIV, ST_OUT} state_t;

	typedef struct packed {
		logic load;
		logic step;
		op_t  op;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;

	function automatic logic signed [33:0] sat32(input logic signed [65:0] v);
		if (v > 66'(S32_MAX)) return S32_MAX;
		if (v < 66'(S32_MIN)) return S32_MIN;
		return v[33:0];
	endfunction

	function automatic logic signed [33:0] scale_in(input logic signed [31:0] x);
		logic signed [65:0] e;
		e = 66'(x);
		if (VOLUME_SHIFT <= 12) return sat32(e <<< (12 - VOLUME_SHIFT));
		return sat32(e >>> (VOLUME_SHIFT - 12));
	endfunction
endpackage

### design/stu_if.sv
// Valid/ready channel carrying a packed word.
// Depends on nothing.
`timescale 1ns / 1ps
interface stu_if #(parameter int W = 64) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/stereo_to_surround_upmix.sv
// Stereo to 5.1 upmix top level: configuration registers, controller, datapath.
// From input accept to output valid the block runs 20 steps and two divisions
// (start, 64 quotient bits, capture each), then one output load.
// One word at a time: a new input word is accepted only after the previous one is loaded to the output.
// Reset clears envelopes, gains to defaults, handshake state idle.
`timescale 1ns / 1ps
module stereo_to_surround_upmix import stu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	stu_if.sink in_ch,
	stu_if.source out_ch,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] gain_q [7];
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[REG_GAIN_LEFT] <= 16'd58982;
			gain_q[REG_GAIN_RIGHT] <= 16'd58982;
			gain_q[REG_GAIN_CENTER] <= 16'd52429;
			gain_q[REG_GAIN_LFE] <= 16'd62259;
			gain_q[REG_GAIN_REAR_LEFT] <= 16'd58982;
			gain_q[REG_GAIN_REAR_RIGHT] <= 16'd58982;
			gain_q[REG_CENTER_BLEND] <= 16'd13107;
		end else if (cfg_we && cfg_index <= REG_CENTER_BLEND) begin
			gain_q[cfg_index] <= cfg_data;
		end
	end

	stu_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd);

	stu_datapath u_dp (.clk, .arst_n, .cmd, .sts, .left_sample(in_ch.data[31:0]),
		.right_sample(in_ch.data[63:32]), .gain_q, .out_word(out_ch.data));

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.div_busy) else $error("load while dividing");
	a_outload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_ch.valid) else $error("output not shown");
endmodule

### design/stu_divider.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on stu_pkg.
`timescale 1ns / 1ps
module stu_divider import stu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] num,
	input  logic [29:0] den,
	output logic busy,
	output logic signed [33:0] quot
);
	logic [63:0] mag_q, quo_q;
	logic [64:0] rem_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic [64:0] shifted;
	logic [64:0] trial;
	logic signed [65:0] sq;

	always_comb begin
		shifted = {rem_q[63:0], mag_q[63]};
		trial = shifted - 65'(den);
		sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		quot = sat32(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63];
			mag_q <= num[63] ? 64'(-num) : 64'(num);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != 0) begin
			mag_q <= {mag_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != 0;
endmodule

### design/stu_datapath.sv
// Datapath: registers, divider, one shared multiply per cycle when stepped.
// Depends on stu_pkg and stu_divider.
`timescale 1ns / 1ps
module stu_datapath import stu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic signed [31:0] left_sample,
	input  logic signed [31:0] right_sample,
	input  logic [15:0] gain_q [7],
	output logic [191:0] out_word
);
	logic signed [33:0] il_q, ir_q, al_q, ar_q, bal_q, front_q, rear_q, c_q;
	logic signed [33:0] l_q, r_q, vl_q, vr_q, t_q, sl_q, sr_q, cx_q;
	logic signed [33:0] o_q [6];
	logic [31:0] env_l_q, env_r_q;
	logic signed [33:0] ma, mb, res, bc;
	logic [5:0] sh;
	logic signed [67:0] prod;
	logic signed [65:0] pv;
	logic div_start;
	logic signed [63:0] div_num;
	logic [29:0] div_den;
	logic signed [33:0] quot;
	logic signed [33:0] pa;

	stu_divider u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.busy(sts.div_busy), .quot);

	always_comb begin
		bc = bal_q;
		if (bc > K_CLAMP) bc = K_CLAMP;
		if (bc < -K_CLAMP) bc = -K_CLAMP;
		div_start = cmd.div_start;
		div_num = (cmd.op == OP_DIV_L) ? 64'(l_q) <<< 28 : 64'(r_q) <<< 28;
		div_den = (cmd.op == OP_DIV_L) ? 30'(Q_ONE - bc) : 30'(Q_ONE + bc);
		ma = '0; mb = '0; sh = 6'd28;
		pa = 34'(env_l_q);
		unique case (cmd.op)
			OP_ENV_L: begin pa = il_q[33] ? -il_q : il_q;
				if (pa > S32_MAX) pa = S32_MAX;
				ma = pa - 34'(env_l_q); mb = K_ENV; end
			OP_ENV_R: begin pa = ir_q[33] ? -ir_q : ir_q;
				if (pa > S32_MAX) pa = S32_MAX;
				ma = pa - 34'(env_r_q); mb = K_ENV; end
			OP_L: begin ma = sat32(66'(il_q) - 66'(c_q)); mb = front_q; end
			OP_R: begin ma = sat32(66'(ir_q) - 66'(c_q)); mb = front_q; end
			OP_SL_A, OP_SR_B: begin ma = vr_q; mb = (cmd.op == OP_SL_A) ? K_MAJOR : K_MINOR; end
			OP_SL_B, OP_SR_A: begin ma = vl_q; mb = (cmd.op == OP_SL_B) ? K_MINOR : K_MAJOR; end
			OP_SL_C: begin ma = sl_q; mb = K_REAR; end
			OP_SR_C: begin ma = sr_q; mb = K_REAR; end
			OP_SL_D: begin ma = sl_q; mb = rear_q; end
			OP_SR_D: begin ma = sr_q; mb = rear_q; end
			OP_CX: begin ma = c_q; mb = 34'(gain_q[REG_CENTER_BLEND]); sh = 6'd12; end
			OP_FL: begin ma = l_q; mb = 34'(gain_q[REG_GAIN_LEFT]); sh = 6'd12; end
			OP_FR: begin ma = r_q; mb = 34'(gain_q[REG_GAIN_RIGHT]); sh = 6'd12; end
			OP_C: begin ma = c_q; mb = 34'(gain_q[REG_GAIN_CENTER]); sh = 6'd12; end
			OP_LFE: begin ma = c_q; mb = 34'(gain_q[REG_GAIN_LFE]); sh = 6'd12; end
			OP_RL: begin ma = sl_q; mb = 34'(gain_q[REG_GAIN_REAR_LEFT]); sh = 6'd12; end
			OP_RR: begin ma = sr_q; mb = 34'(gain_q[REG_GAIN_REAR_RIGHT]); sh = 6'd12; end
			default: ;
		endcase
		prod = ma * mb;
		pv = 66'(prod >>> sh);
		res = sat32(pv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_l_q <= '0;
			env_r_q <= '0;
		end else if (cmd.step && cmd.op == OP_ENV_L) begin
			env_l_q <= 32'(sat32(66'(env_l_q) + pv) < 0 ? 34'sd0 :
				sat32(66'(env_l_q) + pv));
		end else if (cmd.step && cmd.op == OP_ENV_R) begin
			env_r_q <= 32'(sat32(66'(env_r_q) + pv) < 0 ? 34'sd0 :
				sat32(66'(env_r_q) + pv));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			il_q <= scale_in(left_sample);
			ir_q <= scale_in(right_sample);
		end
		if (cmd.step) begin
			unique case (cmd.op)
				OP_ENV_L: al_q <= sat32(66'(env_l_q) + pv) < 0 ? 34'sd0 :
					sat32(66'(env_l_q) + pv);
				OP_ENV_R: begin
					ar_q <= sat32(66'(env_r_q) + pv) < 0 ? 34'sd0 : sat32(66'(env_r_q) + pv);
					c_q <= (il_q + ir_q) >>> 1;
				end
				OP_FRONT: begin
					bal_q <= ar_q - al_q;
					front_q <= (ar_q < al_q) ? al_q - ar_q : ar_q - al_q;
					rear_q <= Q_ONE - ((ar_q < al_q) ? al_q - ar_q : ar_q - al_q);
				end
				OP_L: l_q <= res;
				OP_R: r_q <= res;
				OP_DIV_L: vl_q <= quot;
				OP_DIV_R: vr_q <= quot;
				OP_SL_A, OP_SR_A: t_q <= res;
				OP_SL_B: sl_q <= sat32(66'(t_q) - 66'(res));
				OP_SR_B: sr_q <= sat32(66'(res) - 66'(t_q));
				OP_SL_C, OP_SL_D: sl_q <= res;
				OP_SR_C, OP_SR_D: sr_q <= res;
				OP_CX: cx_q <= res;
				OP_FL: o_q[0] <= sat32(66'(res) + 66'(cx_q));
				OP_FR: o_q[1] <= sat32(66'(res) + 66'(cx_q));
				OP_C: o_q[2] <= res;
				OP_LFE: o_q[3] <= res;
				OP_RL: o_q[4] <= res;
				OP_RR: o_q[5] <= res;
				default: ;
			endcase
		end
		if (cmd.out_load)
			out_word <= {o_q[5][31:0], o_q[4][31:0], o_q[3][31:0],
				o_q[2][31:0], o_q[1][31:0], o_q[0][31:0]};
	end
endmodule

### design/stu_ctrl.sv
// Sequencer: steps through the operation list and waits on the divider and on the output handshake.
// Depends on stu_pkg.
`timescale 1ns / 1ps
module stu_ctrl import stu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	op_t op_q, op_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_ENV_L;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		cmd.op = op_q;
		in_ready = state_q == ST_IDLE;
		out_valid = ov_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				op_d = OP_ENV_L;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (op_q == OP_DIV_L || op_q == OP_DIV_R) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.step = 1'b1;
					if (op_q == OP_RR) state_d = ST_OUT;
					else op_d = op_t'(op_q + 5'd1);
				end
			end
			ST_DIV: if (!sts.div_busy) begin
				cmd.step = 1'b1;
				op_d = op_t'(op_q + 5'd1);
				state_d = ST_STEP;
			end
			ST_OUT: if (!ov_q || out_ready) begin
				cmd.out_load = 1'b1;
				ov_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### dv/tb_top.sv
// Testbench for stereo_to_surround_upmix: random and directed stereo words, checked
// against an in-bench predictor of the six surround channels held in a scoreboard class.
// Depends on stu_pkg, stu_if and the upmix top level.
`timescale 1ns / 1ps
module tb_top;
	import stu_pkg::*;

	typedef struct packed {
		logic signed [31:0] right_sample;
		logic signed [31:0] left_sample;
	} stereo_t;

	typedef struct packed {
		logic signed [31:0] rear_right;
		logic signed [31:0] rear_left;
		logic signed [31:0] lfe_out;
		logic signed [31:0] center_out;
		logic signed [31:0] front_right;
		logic signed [31:0] front_left;
	} surround_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int N_REGS = 7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	class upmix_scoreboard;
		surround_t expected_q[$];
		longint env_l, env_r;
		logic [15:0] gain[N_REGS];
		int errors, reported, checked;

		function new();
			env_l = 0;
			env_r = 0;
			gain[REG_GAIN_LEFT] = 16'd58982;
			gain[REG_GAIN_RIGHT] = 16'd58982;
			gain[REG_GAIN_CENTER] = 16'd52429;
			gain[REG_GAIN_LFE] = 16'd62259;
			gain[REG_GAIN_REAR_LEFT] = 16'd58982;
			gain[REG_GAIN_REAR_RIGHT] = 16'd58982;
			gain[REG_CENTER_BLEND] = 16'd13107;
			errors = 0;
			reported = 0;
			checked = 0;
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint mulq(longint a, longint b);
			return sat((a * b) >>> 28);
		endfunction

		function longint scaled(logic signed [31:0] x);
			longint v;
			v = longint'(x);
			if (VOLUME_SHIFT <= 12) return sat(v <<< (12 - VOLUME_SHIFT));
			return v >>> (VOLUME_SHIFT - 12);
		endfunction

		function longint follow(longint acc, longint x);
			longint p;
			p = x < 0 ? -x : x;
			if (p > 64'sd2147483647) p = 64'sd2147483647;
			acc = acc + (((p - acc) * 64'sd26843546) >>> 28);
			if (acc < 0) acc = 0;
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
			return acc;
		endfunction

		function longint amplify(longint v, logic [15:0] g);
			return sat((v * longint'({48'd0, g})) >>> 12);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx < N_REGS) gain[idx] = val;
		endfunction

		function void note_pair(stereo_t w);
			longint il, ir, bal, front, rear, c, l, r, b, vl, vr, sl, sr, cx;
			surround_t o;
			il = scaled(w.left_sample);
			ir = scaled(w.right_sample);
			env_l = follow(env_l, il);
			env_r = follow(env_r, ir);
			bal = env_r - env_l;
			front = bal < 0 ? -bal : bal;
			rear = 64'sd268435456 - front;
			c = (il + ir) >>> 1;
			l = mulq(sat(il - c), front);
			r = mulq(sat(ir - c), front);
			b = bal;
			if (b > 64'sd241591910) b = 64'sd241591910;
			if (b < -64'sd241591910) b = -64'sd241591910;
			vl = sat((l * 64'sd268435456) / (64'sd268435456 - b));
			vr = sat((r * 64'sd268435456) / (64'sd268435456 + b));
			sl = sat(mulq(vr, 64'sd464393339) - mulq(vl, 64'sd327491256));
			sr = sat(mulq(vr, 64'sd327491256) - mulq(vl, 64'sd464393339));
			sl = mulq(mulq(sl, 64'sd182536110), rear);
			sr = mulq(mulq(sr, 64'sd182536110), rear);
			cx = amplify(c, gain[REG_CENTER_BLEND]);
			o.front_left = 32'(sat(amplify(l, gain[REG_GAIN_LEFT]) + cx));
			o.front_right = 32'(sat(amplify(r, gain[REG_GAIN_RIGHT]) + cx));
			o.center_out = 32'(amplify(c, gain[REG_GAIN_CENTER]));
			o.lfe_out = 32'(amplify(c, gain[REG_GAIN_LFE]));
			o.rear_left = 32'(amplify(sl, gain[REG_GAIN_REAR_LEFT]));
			o.rear_right = 32'(amplify(sr, gain[REG_GAIN_REAR_RIGHT]));
			expected_q.push_back(o);
		endfunction

		function void check_result(surround_t got);
			surround_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("ERROR: unexpected output word %h", got);
				end
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("ERROR: word %0d mismatch", checked);
					$display("  exp FL %0d FR %0d C %0d LFE %0d RL %0d RR %0d",
						want.front_left, want.front_right, want.center_out,
						want.lfe_out, want.rear_left, want.rear_right);
					$display("  got FL %0d FR %0d C %0d LFE %0d RL %0d RR %0d",
						got.front_left, got.front_right, got.center_out,
						got.lfe_out, got.rear_left, got.rear_right);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	stu_if #(.W(64)) in_ch (clk);
	stu_if #(.W(192)) out_ch (clk);

	stereo_to_surround_upmix i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	upmix_scoreboard sb;
	int hold_off;
	bit sink_busy_free;
	int idle_cycles;
	int words_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(15, 80);
	endfunction

	function automatic logic signed [31:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1, 2: return $urandom();
			3: return $signed(32'($urandom_range(0, 2047))) - 32'sd1024;
			default: return $signed(32'($urandom_range(0, 32'h3fffffff))) - 32'sh20000000;
		endcase
	endfunction

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_pair(logic signed [31:0] l, logic signed [31:0] r, bit gaps);
		stereo_t w;
		int g;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		w.left_sample = l;
		w.right_sample = r;
		in_ch.valid = 1'b1;
		in_ch.data = w;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_pair(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// sink: random back-pressure, with one long hold-off on request, or always ready when sink_busy_free is set
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready = 1'b0;
				hold_off--;
			end else if (sink_busy_free) begin
				out_ch.ready = 1'b1;
			end else begin
				out_ch.ready = pick_gap() == 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(surround_t'(out_ch.data));
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: watchdog expired, %0d words outstanding", sb.expected_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] l, r;
		sb = new();
		hold_off = 0;
		sink_busy_free = 1'b0;
		idle_cycles = 0;
		words_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed and random words with the defaults after reset
		send_pair(32'sd0, 32'sd0, 1'b0);
		send_pair(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_pair(32'sh80000000, 32'sh80000000, 1'b0);
		send_pair(32'sh7fffffff, 32'sh80000000, 1'b0);
		send_pair(32'sh80000000, 32'sh7fffffff, 1'b0);
		send_pair(32'sh10000000, 32'sd0, 1'b1);
		send_pair(32'sd0, 32'sh10000000, 1'b1);
		send_pair(32'sh10000000, -32'sh10000000, 1'b1);
		send_pair(-32'sd1, 32'sd1, 1'b1);
		send_pair(-32'sd1, -32'sd1, 1'b1);
		repeat (6) send_pair(32'sh7fffffff, 32'sd0, 1'b1);
		repeat (6) send_pair(32'sd0, 32'sh80000000, 1'b1);
		send_pair(32'sh55555555, 32'shaaaaaaaa, 1'b1);
		send_pair(32'shaaaaaaaa, 32'sh55555555, 1'b1);
		repeat (120) send_pair(pick_sample(), pick_sample(), 1'b1);
		drain();

		// all gains zero, plus a write to an unused index and a long sink hold-off
		for (int i = 0; i < N_REGS; i++) write_cfg(i[CFG_IDX_W-1:0], 16'h0000);
		write_cfg(REG_UNUSED, 16'hffff);
		send_pair(32'sh7fffffff, 32'sh80000000, 1'b0);
		hold_off = 1500;
		repeat (120) send_pair(pick_sample(), pick_sample(), 1'b1);
		drain();

		// all gains at full scale, no idling on either side
		for (int i = 0; i < N_REGS; i++) write_cfg(i[CFG_IDX_W-1:0], 16'hffff);
		sink_busy_free = 1'b1;
		send_pair(32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_pair(32'sh80000000, 32'sh7fffffff, 1'b0);
		repeat (120) send_pair(pick_sample(), pick_sample(), 1'b0);
		sink_busy_free = 1'b0;
		drain();

		// random gains, several settings
		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < N_REGS; i++) write_cfg(i[CFG_IDX_W-1:0], 16'($urandom()));
			for (int k = 0; k < 90; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					l = pick_sample();
					r = l + ($signed(32'($urandom_range(0, 255))) - 32'sd128);
				end else begin
					l = pick_sample();
					r = pick_sample();
				end
				send_pair(l, r, 1'b1);
			end
			drain();
		end

		$display("Summary: %0d stereo words over six gain settings, %0d surround words checked",
			words_sent, sb.checked);
		$display("Covered full-scale, zero and random gains, long sink hold-off and full-rate run");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d words outstanding", sb.errors, sb.expected_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

### filelist.f
design/stu_pkg.sv
design/stu_if.sv
design/stu_divider.sv
design/stu_datapath.sv
design/stu_ctrl.sv
design/stereo_to_surround_upmix.sv
dv/tb_top.sv
